FILE: rtl/psfa_pkg.sv
// Shared types and constants for the packed single-precision arithmetic unit.
// Depends on nothing; used by psfa_lane and packed_single_float_arith.
package psfa_pkg;

    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_SUB = 2'd1;
    localparam logic [1:0] K_MUL = 2'd2;
    localparam logic [1:0] K_DIV = 2'd3;

    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = 13;
    localparam int LAT        = 6 + DIV_STAGES;

    typedef struct packed {
        logic [1:0]         kind;
        logic               spec;
        logic [31:0]        spec_val;
        logic               sa;
        logic               sb;
        logic [23:0]        ma;
        logic signed [11:0] ea;
        logic [23:0]        mb;
        logic signed [11:0] eb;
    } t_unp;

    typedef struct packed {
        logic [1:0]         kind;
        logic               spec;
        logic [31:0]        spec_val;
        logic               sgn;
        logic               eff_sub;
        logic signed [11:0] ex;
        logic [47:0]        mx;
        logic [26:0]        my;
        logic [24:0]        rem;
        logic [25:0]        quo;
        logic [23:0]        dv;
    } t_ls;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sgn;
        logic               ovf;
        logic               tiny;
        logic [47:0]        m;
        logic signed [11:0] e;
        logic [5:0]         lz;
        logic [7:0]         bexp;
    } t_nrm;

endpackage

FILE: rtl/packed_single_float_arith.sv
// Top level of the four-lane packed binary32 add/subtract/multiply/divide unit.
// Depends on psfa_pkg and psfa_lane.
//
// Usage:
//   Request channel: drive i_kind (0 add, 1 subtract, 2 multiply, 3 divide) and
//   the eight operand lanes, and raise i_start. A request is taken on every
//   rising edge where i_start is high and o_busy is low; o_busy is high only
//   while i_rst_n is low, so one request can enter on every cycle.
//   Result channel: o_valid is high for exactly one cycle with the four result
//   lanes; the receiver must take them in that cycle, it cannot hold them off.
//   Pipeline: a request passes through 19 register stages before its result
//   lanes are shown with o_valid. Throughput: one request per cycle.
//   The depth is set by the divider, which retires two quotient bits in each
//   of its 13 stages; add and multiply travel the same pipe.
//   Reset: i_rst_n low at a rising edge clears all in-flight requests; no
//   result strobes follow for requests taken before reset.
module packed_single_float_arith (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_dst_lane0,
    input  logic [31:0] i_dst_lane1,
    input  logic [31:0] i_dst_lane2,
    input  logic [31:0] i_dst_lane3,
    input  logic [31:0] i_src_lane0,
    input  logic [31:0] i_src_lane1,
    input  logic [31:0] i_src_lane2,
    input  logic [31:0] i_src_lane3,
    output logic        o_valid,
    output logic [31:0] o_res_lane0,
    output logic [31:0] o_res_lane1,
    output logic [31:0] o_res_lane2,
    output logic [31:0] o_res_lane3
);
    import psfa_pkg::*;

    logic [LAT-1:0] r_vld, n_vld;
    logic [31:0]    w_dst [4];
    logic [31:0]    w_src [4];
    logic [31:0]    w_res [4];

    assign w_dst[0] = i_dst_lane0;
    assign w_dst[1] = i_dst_lane1;
    assign w_dst[2] = i_dst_lane2;
    assign w_dst[3] = i_dst_lane3;
    assign w_src[0] = i_src_lane0;
    assign w_src[1] = i_src_lane1;
    assign w_src[2] = i_src_lane2;
    assign w_src[3] = i_src_lane3;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        psfa_lane u_lane (
            .i_clk  (i_clk),
            .i_kind (i_kind),
            .i_dst  (w_dst[g]),
            .i_src  (w_src[g]),
            .o_res  (w_res[g])
        );
    end

    // advance the request valid bits with the data
    always_comb begin
        n_vld = {r_vld[LAT-2:0], i_start & ~o_busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_busy      = ~i_rst_n;
    assign o_valid     = r_vld[LAT-1];
    assign o_res_lane0 = w_res[0];
    assign o_res_lane1 = w_res[1];
    assign o_res_lane2 = w_res[2];
    assign o_res_lane3 = w_res[3];

    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_strobe_has_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without request");

    a_dst_nan_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_dst_lane0[30:23] == 8'hFF && i_dst_lane0[22:0] != 23'd0, LAT)
        |-> o_res_lane0 == $past(i_dst_lane0 | QUIET_BIT, LAT))
        else $error("destination NaN not returned quiet");

endmodule

FILE: rtl/psfa_lane.sv
// One binary32 lane: unpack, add/multiply/divide, normalize and round to nearest even.
// Depends on psfa_pkg.
module psfa_lane (
    input  logic        i_clk,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_dst,
    input  logic [31:0] i_src,
    output logic [31:0] o_res
);
    import psfa_pkg::*;

    function automatic logic [4:0] clz24(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] clz48(input logic [47:0] m);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic f_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_inf(input logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    function automatic logic f_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [35:0] unpack(input logic [31:0] x);
        logic [23:0]        m;
        logic signed [11:0] e;
        logic [4:0]         lz;
        m  = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
        e  = (x[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, x[30:23]}) - 12'sd150;
        lz = clz24(m);
        return {m << lz, e - $signed({7'b0, lz})};
    endfunction

    function automatic t_ls div_step(input t_ls s, input logic first);
        t_ls         o;
        logic [24:0] r;
        logic [25:0] q;
        o = s;
        r = s.rem;
        q = s.quo;
        if (s.kind == K_DIV) begin
            for (int j = 0; j < DIV_BITS; j++) begin
                if (r >= {1'b0, s.dv}) begin
                    r = (r - {1'b0, s.dv}) << 1;
                    q = {q[24:0], 1'b1};
                end else begin
                    r = r << 1;
                    q = {q[24:0], 1'b0};
                end
            end
            o.rem = r;
            o.quo = q;
        end else if (first && s.kind != K_MUL) begin
            o.mx = s.eff_sub ? s.mx - 48'(s.my) : s.mx + 48'(s.my);
        end
        return o;
    endfunction

    t_unp n_s1, r_s1;
    t_ls  n_s2, r_s2;
    t_ls  r_dv [DIV_STAGES];
    t_nrm n_n1, r_n1, n_n2, r_n2, n_n3, r_n3;
    logic [31:0] n_out, r_out;

    // unpack and resolve special operands
    always_comb begin
        logic na, nb, ia, ib, za, zb, sa, sb, s;
        na = f_nan(i_dst);
        nb = f_nan(i_src);
        ia = f_inf(i_dst);
        ib = f_inf(i_src);
        za = f_zero(i_dst);
        zb = f_zero(i_src);
        sa = i_dst[31];
        sb = i_src[31] ^ (i_kind == K_SUB);
        s  = sa ^ sb;
        n_s1.kind = i_kind;
        n_s1.sa   = sa;
        n_s1.sb   = sb;
        {n_s1.ma, n_s1.ea} = unpack(i_dst);
        {n_s1.mb, n_s1.eb} = unpack(i_src);
        n_s1.spec     = 1'b1;
        n_s1.spec_val = 32'd0;
        if (na) begin
            n_s1.spec_val = i_dst | QUIET_BIT;
        end else if (nb) begin
            n_s1.spec_val = i_src | QUIET_BIT;
        end else begin
            case (i_kind)
                K_ADD, K_SUB: begin
                    if (ia) n_s1.spec_val = (ib && sa != sb) ? DEFAULT_NAN : i_dst;
                    else if (ib) n_s1.spec_val = {sb, i_src[30:0]};
                    else if (za && zb) n_s1.spec_val = {sa & sb, 31'd0};
                    else if (zb) n_s1.spec_val = i_dst;
                    else if (za) n_s1.spec_val = {sb, i_src[30:0]};
                    else n_s1.spec = 1'b0;
                end
                K_MUL: begin
                    if (ia || ib) n_s1.spec_val = (za || zb) ? DEFAULT_NAN : {s, INF_MAG};
                    else if (za || zb) n_s1.spec_val = {s, 31'd0};
                    else n_s1.spec = 1'b0;
                end
                default: begin
                    if (ia) n_s1.spec_val = ib ? DEFAULT_NAN : {s, INF_MAG};
                    else if (ib) n_s1.spec_val = {s, 31'd0};
                    else if (zb) n_s1.spec_val = za ? DEFAULT_NAN : {s, INF_MAG};
                    else if (za) n_s1.spec_val = {s, 31'd0};
                    else n_s1.spec = 1'b0;
                end
            endcase
        end
    end

    // align for add, multiply, or seed the divider
    always_comb begin
        logic               swap;
        logic [23:0]        mbig, msml;
        logic signed [11:0] ebig, d;
        logic [26:0]        sm;
        logic [47:0]        prod;
        n_s2          = '0;
        n_s2.kind     = r_s1.kind;
        n_s2.spec     = r_s1.spec;
        n_s2.spec_val = r_s1.spec_val;
        swap = (r_s1.ea < r_s1.eb) || (r_s1.ea == r_s1.eb && r_s1.ma < r_s1.mb);
        mbig = swap ? r_s1.mb : r_s1.ma;
        msml = swap ? r_s1.ma : r_s1.mb;
        ebig = swap ? r_s1.eb : r_s1.ea;
        d    = swap ? r_s1.eb - r_s1.ea : r_s1.ea - r_s1.eb;
        sm   = {msml, 3'b0};
        prod = r_s1.ma * r_s1.mb;
        case (r_s1.kind)
            K_ADD, K_SUB: begin
                if (d >= 12'sd27) begin
                    n_s2.my = 27'd1;
                end else begin
                    n_s2.my = (sm >> d[4:0])
                            | 27'(|(sm & ~(27'h7FF_FFFF << d[4:0])));
                end
                n_s2.mx      = {21'd0, mbig, 3'b0};
                n_s2.sgn     = swap ? r_s1.sb : r_s1.sa;
                n_s2.eff_sub = r_s1.sa != r_s1.sb;
                n_s2.ex      = ebig - 12'sd3;
                if (!r_s1.spec && r_s1.sa != r_s1.sb && r_s1.ea == r_s1.eb
                    && r_s1.ma == r_s1.mb) begin
                    n_s2.spec     = 1'b1;
                    n_s2.spec_val = 32'd0;
                end
            end
            K_MUL: begin
                n_s2.mx  = prod;
                n_s2.ex  = r_s1.ea + r_s1.eb;
                n_s2.sgn = r_s1.sa ^ r_s1.sb;
            end
            default: begin
                n_s2.rem = {1'b0, r_s1.ma};
                n_s2.dv  = r_s1.mb;
                n_s2.ex  = r_s1.ea - r_s1.eb - 12'sd26;
                n_s2.sgn = r_s1.sa ^ r_s1.sb;
            end
        endcase
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_dv[k] <= div_step(r_s2, 1'b1);
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                r_dv[k] <= div_step(r_dv[k-1], 1'b0);
            end
        end
    end

    // merge paths and count leading zeros
    always_comb begin
        t_ls s;
        s             = r_dv[DIV_STAGES-1];
        n_n1          = '0;
        n_n1.spec     = s.spec;
        n_n1.spec_val = s.spec_val;
        n_n1.sgn      = s.sgn;
        case (s.kind)
            K_MUL: begin
                n_n1.m = s.mx;
                n_n1.e = s.ex;
            end
            K_DIV: begin
                n_n1.m = {s.quo, |s.rem, 21'd0};
                n_n1.e = s.ex - 12'sd21;
            end
            default: begin
                n_n1.m = {s.mx[27:0], 20'd0};
                n_n1.e = s.ex - 12'sd20;
            end
        endcase
        n_n1.lz = clz48(n_n1.m);
    end

    // normalize; e becomes the biased exponent
    always_comb begin
        n_n2   = r_n1;
        n_n2.m = r_n1.m << r_n1.lz;
        n_n2.e = r_n1.e - $signed({6'd0, r_n1.lz}) + 12'sd174;
    end

    // detect overflow, denormalize with sticky
    always_comb begin
        logic signed [11:0] t;
        n_n3      = r_n2;
        t         = 12'sd1 - r_n2.e;
        n_n3.ovf  = r_n2.e >= 12'sd255;
        n_n3.tiny = 1'b0;
        n_n3.bexp = 8'd0;
        if (r_n2.e >= 12'sd1) begin
            n_n3.bexp = 8'(r_n2.e - 12'sd1);
        end else if (t >= 12'sd25) begin
            n_n3.tiny = 1'b1;
        end else begin
            n_n3.m = (r_n2.m >> t[4:0])
                   | 48'(|(r_n2.m & ~(48'hFFFF_FFFF_FFFF << t[4:0])));
        end
    end

    // round to nearest even and pack
    always_comb begin
        logic [24:0] q;
        logic        up;
        q  = {1'b0, r_n3.m[47:24]};
        up = r_n3.m[23] & ((|r_n3.m[22:0]) | r_n3.m[24]);
        q  = q + 25'(up);
        if (r_n3.spec) n_out = r_n3.spec_val;
        else if (r_n3.ovf) n_out = {r_n3.sgn, INF_MAG};
        else if (r_n3.tiny) n_out = {r_n3.sgn, 31'd0};
        else n_out = {r_n3.sgn, {r_n3.bexp, 23'd0} + 31'(q)};
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_n1  <= n_n1;
        r_n2  <= n_n2;
        r_n3  <= n_n3;
        r_out <= n_out;
    end

    assign o_res = r_out;

endmodule

FILE: tb/tb_packed_single_float_arith.sv
// Self-checking testbench for packed_single_float_arith: drives add, subtract,
// multiply and divide requests and compares every lane against its own binary32 predictor.
// Depends on psfa_pkg and the packed_single_float_arith RTL.
module tb_packed_single_float_arith;
    import psfa_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] dst [4];
        logic [31:0] src [4];
    } t_req;

    typedef struct {
        logic [31:0] lane [4];
    } t_res;

    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_kind;
    logic [31:0] i_dst_lane0, i_dst_lane1, i_dst_lane2, i_dst_lane3;
    logic [31:0] i_src_lane0, i_src_lane1, i_src_lane2, i_src_lane3;
    logic        o_valid;
    logic [31:0] o_res_lane0, o_res_lane1, o_res_lane2, o_res_lane3;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   mismatches;
    int   gap_left;
    bit   tail_part;
    bit   drain_hold;
    bit   stim_done;

    packed_single_float_arith dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_kind(i_kind),
        .i_dst_lane0(i_dst_lane0), .i_dst_lane1(i_dst_lane1),
        .i_dst_lane2(i_dst_lane2), .i_dst_lane3(i_dst_lane3),
        .i_src_lane0(i_src_lane0), .i_src_lane1(i_src_lane1),
        .i_src_lane2(i_src_lane2), .i_src_lane3(i_src_lane3),
        .o_valid(o_valid),
        .o_res_lane0(o_res_lane0), .o_res_lane1(o_res_lane1),
        .o_res_lane2(o_res_lane2), .o_res_lane3(o_res_lane3)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic bit f_nan(logic [31:0] x);
        return x[30:0] > INF_BITS[30:0];
    endfunction

    function automatic bit f_inf(logic [31:0] x);
        return x[30:0] == INF_BITS[30:0];
    endfunction

    function automatic bit f_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic void split(logic [31:0] x, output logic [63:0] m, output int e);
        if (x[30:23] == 8'd0) begin
            m = {41'd0, x[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] round_to_single(logic [31:0] sgn, int e, logic [63:0] m);
        int b, sh;
        logic [63:0] q, rem, half;
        while (m[63:62] == 2'b00) begin
            m = m << 1;
            e--;
        end
        b = e + 189;
        if (b >= 255) return sgn | INF_BITS;
        sh = (b >= 1) ? 39 : 40 - b;
        if (sh > 63) return sgn;
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        if (b >= 1) return sgn | ((32'(b - 1) << 23) + q[31:0]);
        return sgn | q[31:0];
    endfunction

    function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] sa, sb, st;
        logic [63:0] ma, mb, t;
        int ea, eb, ti, d;
        sa = a & SIGN_MASK;
        sb = b & SIGN_MASK;
        if (f_inf(a)) return (f_inf(b) && sa != sb) ? DEFAULT_NAN : a;
        if (f_inf(b)) return b;
        if (f_zero(a) && f_zero(b)) return sa & sb;
        if (f_zero(b)) return a;
        if (f_zero(a)) return b;
        split(a, ma, ea);
        split(b, mb, eb);
        if (ea < eb || (ea == eb && ma < mb)) begin
            t = ma; ma = mb; mb = t;
            ti = ea; ea = eb; eb = ti;
            st = sa; sa = sb; sb = st;
        end
        ma = ma << 37;
        mb = mb << 37;
        d = ea - eb;
        if (d >= 63) mb = 64'd1;
        else if (d > 0) mb = (mb >> d) | 64'((mb & ((64'd1 << d) - 64'd1)) != 0);
        if (sa == sb) return round_to_single(sa, ea - 37, ma + mb);
        if (ma == mb) return 32'd0;
        return round_to_single(sa, ea - 37, ma - mb);
    endfunction

    function automatic logic [31:0] float_prod(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        logic [63:0] ma, mb;
        int ea, eb;
        s = (a ^ b) & SIGN_MASK;
        if (f_inf(a) || f_inf(b)) begin
            if (f_zero(a) || f_zero(b)) return DEFAULT_NAN;
            return s | INF_BITS;
        end
        if (f_zero(a) || f_zero(b)) return s;
        split(a, ma, ea);
        split(b, mb, eb);
        return round_to_single(s, ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] float_quot(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        logic [63:0] ma, mb, q, r;
        int ea, eb;
        s = (a ^ b) & SIGN_MASK;
        if (f_inf(a)) return f_inf(b) ? DEFAULT_NAN : (s | INF_BITS);
        if (f_inf(b)) return s;
        if (f_zero(b)) return f_zero(a) ? DEFAULT_NAN : (s | INF_BITS);
        if (f_zero(a)) return s;
        split(a, ma, ea);
        split(b, mb, eb);
        while (ma[23] == 1'b0) begin
            ma = ma << 1;
            ea--;
        end
        while (mb[23] == 1'b0) begin
            mb = mb << 1;
            eb--;
        end
        q = (ma << 40) / mb;
        r = (ma << 40) % mb;
        return round_to_single(s, ea - eb - 40, q | 64'(r != 0));
    endfunction

    function automatic logic [31:0] lane_result(logic [1:0] kind, logic [31:0] a,
                                                logic [31:0] b);
        if (f_nan(a)) return a | QUIET_BIT;
        if (f_nan(b)) return b | QUIET_BIT;
        case (kind)
            K_ADD: return float_sum(a, b);
            K_SUB: return float_sum(a, b ^ SIGN_MASK);
            K_MUL: return float_prod(a, b);
            default: return float_quot(a, b);
        endcase
    endfunction

    function automatic t_res packed_result(t_req r);
        t_res x;
        for (int i = 0; i < 4; i++) x.lane[i] = lane_result(r.kind, r.dst[i], r.src[i]);
        return x;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h", what, got, want);
        mismatches++;
    endtask

    // Pick binary32 patterns biased toward special classes and nearby exponents.
    function automatic logic [31:0] pick_operand(logic [31:0] near);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 11))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:0] = 31'd0;
            3: v[30:0] = INF_BITS[30:0];
            4: v[30:23] = 8'(near[30:23] + $urandom_range(0, 4) - 2);
            5: v[30:23] = 8'(near[30:23] + $urandom_range(0, 60) - 30);
            6: v[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'h01;
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_req(logic [1:0] kind, logic [31:0] d, logic [31:0] s);
        t_req r;
        r.kind = kind;
        for (int i = 0; i < 4; i++) begin
            r.dst[i] = (i == 0) ? d : pick_operand(d);
            r.src[i] = (i == 0) ? s : pick_operand(r.dst[i]);
        end
        pending_reqs.push_back(r);
    endtask

    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n || drain_hold) begin
            i_start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_start <= 1'b0;
        end else if (!tail_part && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 10);
            i_start <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(i_start && o_busy)) begin
            r = pending_reqs.pop_front();
            i_start <= 1'b1;
            i_kind <= r.kind;
            {i_dst_lane0, i_dst_lane1, i_dst_lane2, i_dst_lane3} <=
                {r.dst[0], r.dst[1], r.dst[2], r.dst[3]};
            {i_src_lane0, i_src_lane1, i_src_lane2, i_src_lane3} <=
                {r.src[0], r.src[1], r.src[2], r.src[3]};
        end else if (!(i_start && o_busy)) begin
            i_start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_req r;
        t_res want;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                r.kind = i_kind;
                r.dst = '{i_dst_lane0, i_dst_lane1, i_dst_lane2, i_dst_lane3};
                r.src = '{i_src_lane0, i_src_lane1, i_src_lane2, i_src_lane3};
                expected_res.push_back(packed_result(r));
            end
            if (o_valid) begin
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected result lane0", o_res_lane0, 32'd0);
                end else begin
                    want = expected_res.pop_front();
                    if (o_res_lane0 !== want.lane[0])
                        report_mismatch("lane0", o_res_lane0, want.lane[0]);
                    if (o_res_lane1 !== want.lane[1])
                        report_mismatch("lane1", o_res_lane1, want.lane[1]);
                    if (o_res_lane2 !== want.lane[2])
                        report_mismatch("lane2", o_res_lane2, want.lane[2]);
                    if (o_res_lane3 !== want.lane[3])
                        report_mismatch("lane3", o_res_lane3, want.lane[3]);
                end
            end
        end
    end

    initial begin
        logic [31:0] edge_vals [12];
        logic [1:0] k;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = K_ADD;
        {i_dst_lane0, i_dst_lane1, i_dst_lane2, i_dst_lane3} = '0;
        {i_src_lane0, i_src_lane1, i_src_lane2, i_src_lane3} = '0;
        mismatches = 0;
        gap_left = 0;
        tail_part = 1'b0;
        drain_hold = 1'b0;
        stim_done = 1'b0;
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                      32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
                      32'h7F7F_FFFF, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h0080_0000};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: each operation over special values, then invalid, cancellation, x/0, overflow, underflow and NaN.
        for (int i = 0; i < 16; i++) begin
            k = 2'(i);
            push_req(k, edge_vals[i % 12], edge_vals[(i * 5 + 3) % 12]);
        end
        push_req(K_SUB, 32'h7F80_0000, 32'h7F80_0000);
        push_req(K_ADD, 32'h3F80_0000, 32'hBF80_0000);
        push_req(K_MUL, 32'h0000_0000, 32'hFF80_0000);
        push_req(K_DIV, 32'h0000_0000, 32'h8000_0000);
        push_req(K_DIV, 32'h7F80_0000, 32'hFF80_0000);
        push_req(K_DIV, 32'hBF80_0000, 32'h0000_0000);
        push_req(K_MUL, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        push_req(K_MUL, 32'h0080_0000, 32'h3EFF_FFFF);
        push_req(K_SUB, 32'h7FA0_0000, 32'hFFC1_2345);

        wait (pending_reqs.size() == 0);
        drain_hold = 1'b1;
        @(negedge i_clk);
        wait (expected_res.size() == 0);
        @(negedge i_clk);
        drain_hold = 1'b0;

        for (int n = 0; n < 900; n++) begin
            if (n == 780) tail_part = 1'b1;
            k = 2'($urandom_range(0, 3));
            push_req(k, pick_operand($urandom), pick_operand($urandom));
            if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
        end
        wait (pending_reqs.size() == 0);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (expected_res.size() == 0);
        repeat (LAT + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("** packed_single_float_arith: PASSED **");
        end else begin
            $display("** packed_single_float_arith: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** packed_single_float_arith: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/psfa_pkg.sv
rtl/psfa_lane.sv
rtl/packed_single_float_arith.sv
tb/tb_packed_single_float_arith.sv
